// ----- hdl/sbi_pkg.sv -----
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared constants and types for the script bytecode interpreter.
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int PROGRAM_DEPTH_DEF  = 256;
    localparam int VARIABLE_COUNT_DEF = 32;
    localparam int STACK_DEPTH_DEF    = 8;

    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_STEP   = 2'd2;
    localparam logic [1:0] ACT_RSVD   = 2'd3;

    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_ADD  = 8'h01;
    localparam logic [7:0] OP_SUB  = 8'h02;
    localparam logic [7:0] OP_MUL  = 8'h03;
    localparam logic [7:0] OP_DIV  = 8'h04;
    localparam logic [7:0] OP_MOD  = 8'h05;
    localparam logic [7:0] OP_AND  = 8'h06;
    localparam logic [7:0] OP_OR   = 8'h07;
    localparam logic [7:0] OP_NE   = 8'h08;
    localparam logic [7:0] OP_EQ   = 8'h09;
    localparam logic [7:0] OP_GT   = 8'h0A;
    localparam logic [7:0] OP_GE   = 8'h0B;
    localparam logic [7:0] OP_LT   = 8'h0C;
    localparam logic [7:0] OP_LE   = 8'h0D;
    localparam logic [7:0] OP_SHL  = 8'h0E;
    localparam logic [7:0] OP_SHR  = 8'h0F;
    localparam logic [7:0] OP_GOTO = 8'h10;
    localparam logic [7:0] OP_WAIT = 8'h11;
    localparam logic [7:0] OP_GET  = 8'h12;
    localparam logic [7:0] OP_SET  = 8'h13;
    localparam logic [7:0] OP_IF   = 8'h14;
    localparam logic [7:0] OP_CALL = 8'h15;
    localparam logic [7:0] OP_RET  = 8'h16;
    localparam logic [7:0] OP_RUN  = 8'h17;
    localparam logic [7:0] OP_DBG  = 8'h18;
    localparam logic [7:0] OP_UNUSED = 8'hFF;

    localparam logic [3:0] TY_VAR  = 4'd0;
    localparam logic [3:0] TY_PER1 = 4'd1;
    localparam logic [3:0] TY_PER2 = 4'd2;
    localparam logic [3:0] TY_PIN  = 4'd3;
    localparam logic [3:0] TY_PER4 = 4'd4;
    localparam logic [3:0] TY_PER5 = 4'd5;
    localparam logic [3:0] TY_PER6 = 4'd6;
    localparam logic [3:0] TY_VER  = 4'd7;
    localparam logic [3:0] TY_IMM  = 4'd8;
    localparam logic [3:0] TY_UNUSED = 4'd15;

    // divider control handed to the shared divide unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;

endpackage

// ----- hdl/script_bytecode_interpreter.sv -----
// ----------------------------------------------------------------------------
// script_bytecode_interpreter
// Accumulator bytecode interpreter with program store, variables and stack.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time. An append, an unused action code or
// a step tick that executes nothing leaves the block idle, and the input is
// ready again at the next edge. An executed instruction, host or stepped (the
// program word is read from the store at the accepting edge), holds the input
// while it passes through fetch, execute, finish and output back to idle. DIV
// and MOD add a divide state that waits out the 32 iterations of the
// bit-serial divider and picks up its result. When tracing is set after
// execution a trace transfer is offered on the master side and held in an
// output register; the next input transfer is taken only after that trace
// has left. The variable store resets to zero through one valid bit per
// entry, so no clearing pass is needed.
module script_bytecode_interpreter #(
    parameter int PROGRAM_DEPTH  = sbi_pkg::PROGRAM_DEPTH_DEF,
    parameter int VARIABLE_COUNT = sbi_pkg::VARIABLE_COUNT_DEF,
    parameter int STACK_DEPTH    = sbi_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: instruction[31:0], pin_levels[63:32]
    input  logic [63:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: trace_pointer[8:0], trace_instruction[40:9],
    // trace_accumulator[72:41], wait_count[103:73], zero pad [111:104]
    output logic [111:0] m_axis_tdata
);
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int VW = $clog2(VARIABLE_COUNT);
    localparam int SW = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_EXEC, S_DIV, S_FINISH, S_OUT
    } t_state;

    t_state r_state;

    logic [31:0] r_prog [PROGRAM_DEPTH];
    logic [31:0] r_vars [VARIABLE_COUNT];
    logic [VARIABLE_COUNT-1:0] r_vvalid;
    logic [8:0]  r_stack [STACK_DEPTH];

    logic [8:0]  r_plen;
    logic [SW:0] r_sdep;
    logic [31:0] r_acc;
    logic [8:0]  r_ip;
    logic        r_running;
    logic        r_tracing;

    logic [31:0] r_ins;
    logic [31:0] r_pins;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [30:0] r_wait;
    logic [31:0] r_res;
    logic        r_neg;

    logic [111:0] r_tdata;
    logic         r_tvalid;

    sbi_pkg::t_div_req w_dreq;
    sbi_pkg::t_div_rsp w_drsp;

    sbi_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    logic [7:0]  w_op;
    logic [3:0]  w_t1, w_t2;
    logic [7:0]  w_a1, w_a2;
    assign w_op = r_ins[31:24];
    assign w_t1 = r_ins[23:20];
    assign w_a1 = r_ins[19:12];
    assign w_t2 = r_ins[11:8];
    assign w_a2 = r_ins[7:0];

    function automatic logic [31:0] f_operand(
        input logic [3:0] ty, input logic [7:0] ad, input logic [31:0] pins,
        input logic [31:0] vval, input logic vok);
        logic [31:0] v;
        v = 32'd0;
        case (ty)
            sbi_pkg::TY_VAR: v = vok ? vval : 32'd0;
            sbi_pkg::TY_PIN: v = (ad < 8'd32) ? {31'd0, pins[ad[4:0]]} : 32'd0;
            sbi_pkg::TY_PER1, sbi_pkg::TY_PER2, sbi_pkg::TY_PER4,
            sbi_pkg::TY_PER5, sbi_pkg::TY_PER6: v = 32'hFFFF_FFFF;
            sbi_pkg::TY_VER: v = 32'd1;
            sbi_pkg::TY_IMM: v = {{24{ad[7]}}, ad};
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] f_jump(input logic [31:0] t);
        return (t > 32'(PROGRAM_DEPTH)) ? 9'(PROGRAM_DEPTH) : t[8:0];
    endfunction

    // variable reads at the two operand addresses
    logic        w_v1ok, w_v2ok;
    logic [31:0] w_v1, w_v2;
    always_comb begin
        w_v1ok = ({24'd0, w_a1} < 32'(VARIABLE_COUNT)) && r_vvalid[w_a1[VW-1:0]];
        w_v2ok = ({24'd0, w_a2} < 32'(VARIABLE_COUNT)) && r_vvalid[w_a2[VW-1:0]];
        w_v1 = r_vars[w_a1[VW-1:0]];
        w_v2 = r_vars[w_a2[VW-1:0]];
    end

    logic w_lt, w_gt;
    assign w_lt = $signed(r_x) < $signed(r_y);
    assign w_gt = $signed(r_y) < $signed(r_x);

    logic [31:0] w_ax, w_ay;
    assign w_ax = r_x[31] ? (32'd0 - r_x) : r_x;
    assign w_ay = r_y[31] ? (32'd0 - r_y) : r_y;

    always_comb begin
        w_dreq.start    = (r_state == S_EXEC) &&
                          (w_op == sbi_pkg::OP_DIV || w_op == sbi_pkg::OP_MOD);
        w_dreq.dividend = w_ax;
        w_dreq.divisor  = w_ay;
    end

    logic w_alu;
    assign w_alu = (w_op >= sbi_pkg::OP_ADD) && (w_op <= sbi_pkg::OP_SHR);

    assign s_axis_tready = (r_state == S_IDLE) && !r_tvalid;
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

    logic [8:0] w_ipn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_plen    <= '0;
            r_sdep    <= '0;
            r_acc     <= '0;
            r_ip      <= '0;
            r_running <= 1'b0;
            r_tracing <= 1'b1;
            r_vvalid  <= '0;
            r_tvalid  <= 1'b0;
        end else begin
            if (r_tvalid && m_axis_tready) r_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_pins <= s_axis_tdata[63:32];
                        case (s_axis_tuser)
                            sbi_pkg::ACT_EXEC: begin
                                r_ins   <= s_axis_tdata[31:0];
                                r_state <= S_FETCH;
                            end
                            sbi_pkg::ACT_APPEND: begin
                                if (r_plen < 9'(PROGRAM_DEPTH)) begin
                                    r_prog[r_plen[PW-1:0]] <= s_axis_tdata[31:0];
                                    r_plen <= r_plen + 9'd1;
                                end
                            end
                            sbi_pkg::ACT_STEP: begin
                                if (r_ip >= r_plen) begin
                                    r_running <= 1'b0;
                                end else if (r_running) begin
                                    // r_ip < r_plen <= depth, so read is in range
                                    r_ins <= r_prog[r_ip[PW-1:0]];
                                    r_state <= S_FETCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FETCH: begin
                    // advance pointer when running and in range, fetch both operands
                    if (r_running && r_ip < r_plen) r_ip <= r_ip + 9'd1;
                    r_x <= f_operand(w_t1, w_a1, r_pins, w_v1, w_v1ok);
                    r_y <= f_operand(w_t2, w_a2, r_pins, w_v2, w_v2ok);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_wait <= (w_op == sbi_pkg::OP_WAIT && !r_x[31]) ? r_x[30:0] : 31'd0;
                    r_neg  <= (w_op == sbi_pkg::OP_MOD) ? r_x[31] : (r_x[31] ^ r_y[31]);
                    // DIV and MOD start the divider and wait for it
                    r_state <= w_dreq.start ? S_DIV : S_FINISH;
                    case (w_op)
                        sbi_pkg::OP_ADD: r_res <= r_x + r_y;
                        sbi_pkg::OP_SUB: r_res <= r_x - r_y;
                        sbi_pkg::OP_MUL: r_res <= r_x * r_y;
                        sbi_pkg::OP_AND: r_res <= r_x & r_y;
                        sbi_pkg::OP_OR:  r_res <= r_x | r_y;
                        sbi_pkg::OP_NE:  r_res <= {31'd0, r_x != r_y};
                        sbi_pkg::OP_EQ:  r_res <= {31'd0, r_x == r_y};
                        sbi_pkg::OP_GT:  r_res <= {31'd0, w_gt};
                        sbi_pkg::OP_GE:  r_res <= {31'd0, !w_lt};
                        sbi_pkg::OP_LT:  r_res <= {31'd0, w_lt};
                        sbi_pkg::OP_LE:  r_res <= {31'd0, !w_gt};
                        sbi_pkg::OP_SHL:
                            r_res <= (r_y >= 32'd32) ? 32'd0 : (r_x << r_y[4:0]);
                        sbi_pkg::OP_SHR:
                            r_res <= (r_y >= 32'd32) ? {32{r_x[31]}}
                                                     : 32'($signed(r_x) >>> r_y[4:0]);
                        sbi_pkg::OP_GOTO: r_ip <= f_jump(r_x);
                        sbi_pkg::OP_GET:  r_acc <= r_x;
                        sbi_pkg::OP_SET: begin
                            if (w_t1 == sbi_pkg::TY_VAR &&
                                {24'd0, w_a1} < 32'(VARIABLE_COUNT)) begin
                                r_vars[w_a1[VW-1:0]] <= r_acc;
                                r_vvalid[w_a1[VW-1:0]] <= 1'b1;
                            end
                        end
                        sbi_pkg::OP_IF: if (r_acc != 32'd0) r_ip <= f_jump(r_x);
                        sbi_pkg::OP_RET: begin
                            if (r_sdep != '0) begin
                                r_sdep <= r_sdep - 1'b1;
                                r_ip <= r_stack[SW'(r_sdep - 1'b1)];
                            end
                        end
                        sbi_pkg::OP_CALL, sbi_pkg::OP_RUN, sbi_pkg::OP_DBG: begin
                            if (w_op == sbi_pkg::OP_RUN) r_tracing <= 1'b0;
                            if (w_op == sbi_pkg::OP_DBG) r_tracing <= 1'b1;
                            if (w_op != sbi_pkg::OP_CALL) r_running <= 1'b1;
                            if (r_sdep < (SW+1)'(STACK_DEPTH)) begin
                                r_stack[r_sdep[SW-1:0]] <= r_ip;
                                r_sdep <= r_sdep + 1'b1;
                                r_ip <= f_jump(r_x);
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        if (w_ay == 32'd0) r_res <= 32'd0;
                        else if (w_op == sbi_pkg::OP_MOD)
                            r_res <= r_neg ? 32'd0 - w_drsp.remainder : w_drsp.remainder;
                        else
                            r_res <= r_neg ? 32'd0 - w_drsp.quotient : w_drsp.quotient;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // commit ALU result, then offer trace
                    if (w_alu) begin
                        r_acc <= r_res;
                        if (w_t1 == sbi_pkg::TY_VAR &&
                            {24'd0, w_a1} < 32'(VARIABLE_COUNT)) begin
                            r_vars[w_a1[VW-1:0]] <= r_res;
                            r_vvalid[w_a1[VW-1:0]] <= 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_tracing) begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= {8'd0, r_wait, r_acc, r_ins, r_ip};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_ipn = r_ip;

    // the stack never grows past its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sdep <= (SW+1)'(STACK_DEPTH))
        else $error("return stack depth overflow");

    // no input is taken while a trace is waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tvalid |-> !s_axis_tready)
        else $error("input accepted with trace pending");

    // the pointer never passes the program depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ipn <= 9'(PROGRAM_DEPTH))
        else $error("instruction pointer out of range");

endmodule

// ----- hdl/sbi_divider.sv -----
// ----------------------------------------------------------------------------
// sbi_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbi_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbi_pkg::t_div_req i_req,
    output sbi_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract if it fits
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the script bytecode interpreter: a directed table
// of host instructions, program loads and step ticks, then random scripts,
// with traces checked against a behavioral model of the interpreter.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PDEPTH = sbi_pkg::PROGRAM_DEPTH_DEF;
    localparam int VCOUNT = sbi_pkg::VARIABLE_COUNT_DEF;
    localparam int SDEPTH = sbi_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [30:0] waitms;
        logic [31:0] acc;
        logic [31:0] ins;
        logic [8:0]  ptr;
    } t_trace;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] ins;
        logic [31:0] pins;
        bit          has_fixed;
        t_trace      fixed;
    } t_stim;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;

    script_bytecode_interpreter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // interpreter state mirror
    logic [31:0] prog_mem [PDEPTH];
    logic [8:0]  prog_len;
    logic [31:0] vars [VCOUNT];
    logic [8:0]  ret_stk [SDEPTH];
    int          stk_cnt;
    logic [31:0] acc_q;
    logic [8:0]  ip_q;
    bit          run_q;
    bit          trace_q;

    t_trace expected_traces[$];
    int     errors = 0;
    int     cycles = 0;
    int     items_sent = 0;
    bit     hold_off = 1'b0;
    t_stim  table_rows[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic logic [31:0] read_operand(logic [3:0] ty, logic [7:0] ad,
                                                 logic [31:0] pins);
        case (ty)
            sbi_pkg::TY_VAR: return (ad < VCOUNT) ? vars[ad] : 32'd0;
            sbi_pkg::TY_PIN: return (ad < 32) ? {31'd0, pins[ad[4:0]]} : 32'd0;
            sbi_pkg::TY_PER1, sbi_pkg::TY_PER2, sbi_pkg::TY_PER4,
            sbi_pkg::TY_PER5, sbi_pkg::TY_PER6: return 32'hFFFF_FFFF;
            sbi_pkg::TY_VER: return 32'd1;
            sbi_pkg::TY_IMM: return {{24{ad[7]}}, ad};
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [8:0] clamp_target(logic [31:0] t);
        return (t > PDEPTH) ? 9'(PDEPTH) : t[8:0];
    endfunction

    function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b, bit rem);
        logic [31:0] ua, ub, r;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        if (ub == 0) return 32'd0;
        if (rem) begin
            r = ua % ub;
            return a[31] ? -r : r;
        end
        r = ua / ub;
        return (a[31] != b[31]) ? -r : r;
    endfunction

    function automatic void push_call(logic [31:0] t);
        if (stk_cnt < SDEPTH) begin
            ret_stk[stk_cnt] = ip_q;
            stk_cnt++;
            ip_q = clamp_target(t);
        end
    endfunction

    // run one instruction on the mirror; queue a trace if tracing stays set
    function automatic void interpret(logic [31:0] ins, logic [31:0] pins);
        logic [7:0]  opc;
        logic [31:0] x, y, r, w;
        bit          alu;
        t_trace      t;
        opc = ins[31:24];
        w = 0;
        r = 0;
        alu = 1;
        if (run_q && ip_q < prog_len) ip_q++;
        x = read_operand(ins[23:20], ins[19:12], pins);
        y = read_operand(ins[11:8], ins[7:0], pins);
        case (opc)
            sbi_pkg::OP_ADD: r = x + y;
            sbi_pkg::OP_SUB: r = x - y;
            sbi_pkg::OP_MUL: r = x * y;
            sbi_pkg::OP_DIV: r = signed_divide(x, y, 0);
            sbi_pkg::OP_MOD: r = signed_divide(x, y, 1);
            sbi_pkg::OP_AND: r = x & y;
            sbi_pkg::OP_OR:  r = x | y;
            sbi_pkg::OP_NE:  r = {31'd0, x != y};
            sbi_pkg::OP_EQ:  r = {31'd0, x == y};
            sbi_pkg::OP_GT:  r = {31'd0, $signed(x) > $signed(y)};
            sbi_pkg::OP_GE:  r = {31'd0, $signed(x) >= $signed(y)};
            sbi_pkg::OP_LT:  r = {31'd0, $signed(x) < $signed(y)};
            sbi_pkg::OP_LE:  r = {31'd0, $signed(x) <= $signed(y)};
            sbi_pkg::OP_SHL: r = (y >= 32) ? 32'd0 : x << y[4:0];
            sbi_pkg::OP_SHR: r = (y >= 32) ? {32{x[31]}} : 32'($signed(x) >>> y[4:0]);
            default: alu = 0;
        endcase
        if (alu) begin
            acc_q = r;
            if (ins[23:20] == sbi_pkg::TY_VAR && ins[19:12] < VCOUNT) vars[ins[19:12]] = r;
        end else begin
            case (opc)
                sbi_pkg::OP_GOTO: ip_q = clamp_target(x);
                sbi_pkg::OP_WAIT: w = x[31] ? 32'd0 : x;
                sbi_pkg::OP_GET:  acc_q = x;
                sbi_pkg::OP_SET:  if (ins[23:20] == sbi_pkg::TY_VAR && ins[19:12] < VCOUNT)
                                      vars[ins[19:12]] = acc_q;
                sbi_pkg::OP_IF:   if (acc_q != 0) ip_q = clamp_target(x);
                sbi_pkg::OP_CALL: push_call(x);
                sbi_pkg::OP_RET:  if (stk_cnt > 0) begin
                                      stk_cnt--;
                                      ip_q = ret_stk[stk_cnt];
                                  end
                sbi_pkg::OP_RUN:  begin trace_q = 0; run_q = 1; push_call(x); end
                sbi_pkg::OP_DBG:  begin trace_q = 1; run_q = 1; push_call(x); end
                default: ;
            endcase
        end
        if (trace_q) begin
            t.ptr = ip_q;
            t.ins = ins;
            t.acc = acc_q;
            t.waitms = w[30:0];
            expected_traces.push_back(t);
        end
    endfunction

    // returns 1 when the item queued a trace
    function automatic bit predict_item(logic [1:0] act, logic [31:0] ins, logic [31:0] pins);
        int n;
        n = expected_traces.size();
        if (act == sbi_pkg::ACT_EXEC) interpret(ins, pins);
        else if (act == sbi_pkg::ACT_APPEND) begin
            if (prog_len < PDEPTH) begin
                prog_mem[prog_len] = ins;
                prog_len++;
            end
        end else if (act == sbi_pkg::ACT_STEP) begin
            if (ip_q >= prog_len) run_q = 0;
            if (run_q && ip_q < PDEPTH) interpret(prog_mem[ip_q], pins);
        end
        return expected_traces.size() != n;
    endfunction

    // drive one transfer and hold it until taken; check a typed-in trace
    task automatic send(input t_stim s);
        bit got;
        t_trace p;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= s.act;
        s_axis_tdata <= {s.pins, s.ins};
        do @(posedge i_clk); while (!s_axis_tready);
        got = predict_item(s.act, s.ins, s.pins);
        if (s.has_fixed) begin
            p = got ? expected_traces[$] : '0;
            if (!got || p != s.fixed) report("table trace", p.acc, s.fixed.acc);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] mk(logic [7:0] op, logic [3:0] t1, logic [7:0] a1,
                                       logic [3:0] t2, logic [7:0] a2);
        return {op, t1, a1, t2, a2};
    endfunction

    // single-operand form; the second operand is variable 0
    function automatic logic [31:0] mk1(logic [7:0] op, logic [3:0] t1, logic [7:0] a1);
        return {op, t1, a1, sbi_pkg::TY_VAR, 8'd0};
    endfunction

    function automatic void row(logic [1:0] act, logic [31:0] ins, logic [31:0] pins,
                                bit fx = 0, logic [8:0] p = 0, logic [31:0] a = 0,
                                logic [30:0] w = 0);
        t_stim s;
        s.act = act; s.ins = ins; s.pins = pins; s.has_fixed = fx;
        s.fixed.ptr = p; s.fixed.ins = ins; s.fixed.acc = a; s.fixed.waitms = w;
        table_rows.push_back(s);
    endfunction

    // result checker on the master side
    always @(posedge i_clk) begin
        t_trace got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[103:0];
            if (expected_traces.size() == 0) report("unexpected trace", got.ins, 0);
            else begin
                exp = expected_traces.pop_front();
                if (got.ptr != exp.ptr) report("trace_pointer", got.ptr, exp.ptr);
                if (got.ins != exp.ins) report("trace_instruction", got.ins, exp.ins);
                if (got.acc != exp.acc) report("trace_accumulator", got.acc, exp.acc);
                if (got.waitms != exp.waitms) report("wait_count", got.waitms, exp.waitms);
            end
        end
    end

    // receiver stall pattern; a long hold-off overrides it
    always @(negedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_off) m_axis_tready <= 1'b0;
        else if ((cycles / 64) % 4 == 3) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // one long receiver hold-off, timed in cycles, once random traffic runs
    initial begin
        wait (items_sent >= 200);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] rand_operand_pair();
        logic [3:0] t1, t2;
        t1 = ($urandom_range(0, 3) != 0) ? sbi_pkg::TY_VAR : 4'($urandom);
        t2 = ($urandom_range(0, 2) == 0) ? sbi_pkg::TY_VAR :
             ($urandom_range(0, 1) ? sbi_pkg::TY_IMM : 4'($urandom));
        return {8'd0, t1, 8'($urandom_range(0, 40)), t2, 8'($urandom)};
    endfunction

    function automatic logic [31:0] rand_flow(int len);
        logic [7:0] op;
        op = 8'($urandom_range(sbi_pkg::OP_GOTO, sbi_pkg::OP_RET));
        return {op, sbi_pkg::TY_IMM, 8'($urandom_range(0, len + 2)), 12'($urandom)};
    endfunction

    initial begin
        int          steps, len, gap;
        logic [31:0] ins;
        prog_len = 0; stk_cnt = 0; acc_q = 0; ip_q = 0; run_q = 0; trace_q = 1;
        foreach (vars[i]) vars[i] = 0;
        foreach (prog_mem[i]) prog_mem[i] = 0;
        foreach (ret_stk[i]) ret_stk[i] = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, divide corners, shifts, operand types, flow
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_NOP, sbi_pkg::TY_VAR, 0), 0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_GET, sbi_pkg::TY_VER, 0), 0, 1, 0, 1);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_GET, sbi_pkg::TY_PER1, 0), 0, 1, 0,
            32'hFFFF_FFFF);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_GET, sbi_pkg::TY_PIN, 31), 32'h8000_0000,
            1, 0, 1);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_GET, sbi_pkg::TY_PIN, 32), 32'hFFFF_FFFF,
            1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_GET, sbi_pkg::TY_IMM, 8'h80), 0, 1, 0,
            32'hFFFF_FF80);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_GET, sbi_pkg::TY_UNUSED, 0), 0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_DIV, sbi_pkg::TY_IMM, 8'h07, sbi_pkg::TY_VAR, 3),
            0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_SHL, sbi_pkg::TY_VAR, 1, sbi_pkg::TY_IMM, 8'h1F),
            0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_ADD, sbi_pkg::TY_VAR, 1, sbi_pkg::TY_PER1, 0),
            0, 1, 0, 32'hFFFF_FFFF);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_SHL, sbi_pkg::TY_VAR, 1, sbi_pkg::TY_IMM, 8'h1F),
            0, 1, 0, 32'h8000_0000);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_DIV, sbi_pkg::TY_VAR, 1, sbi_pkg::TY_IMM, 8'hFF),
            0, 1, 0, 32'h8000_0000);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_MOD, sbi_pkg::TY_IMM, 8'hF9, sbi_pkg::TY_IMM, 2),
            0, 1, 0, 32'hFFFF_FFFF);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_SHR, sbi_pkg::TY_VAR, 1, sbi_pkg::TY_IMM, 8'h40),
            0, 1, 0, 32'hFFFF_FFFF);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_SHL, sbi_pkg::TY_VAR, 1, sbi_pkg::TY_PER1, 0),
            0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_WAIT, sbi_pkg::TY_IMM, 8'h7F), 0, 1, 0, 0, 127);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_WAIT, sbi_pkg::TY_IMM, 8'h80), 0, 1, 0, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_SET, sbi_pkg::TY_VAR, 8'hFF), 0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_RET, sbi_pkg::TY_VAR, 0), 0, 1, 0, 0);
        row(sbi_pkg::ACT_EXEC, mk(sbi_pkg::OP_UNUSED, sbi_pkg::TY_UNUSED, 8'hFF,
                                  sbi_pkg::TY_UNUSED, 8'hFF), 0, 1, 0, 0);
        row(sbi_pkg::ACT_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // short program: compare, add, then jump past the end
        row(sbi_pkg::ACT_APPEND, mk(sbi_pkg::OP_LT, sbi_pkg::TY_VAR, 2, sbi_pkg::TY_IMM, 3), 0);
        row(sbi_pkg::ACT_APPEND, mk(sbi_pkg::OP_ADD, sbi_pkg::TY_VAR, 4, sbi_pkg::TY_IMM, 1), 0);
        row(sbi_pkg::ACT_APPEND, mk1(sbi_pkg::OP_GOTO, sbi_pkg::TY_PER1, 0), 0);
        row(sbi_pkg::ACT_EXEC, mk1(sbi_pkg::OP_DBG, sbi_pkg::TY_IMM, 0), 0);
        for (int i = 0; i < 5; i++) row(sbi_pkg::ACT_STEP, 0, $urandom);
        foreach (table_rows[i]) send(table_rows[i]);
        table_rows.delete();

        // random: mostly loaded scripts stepped with DBG/RUN, some host noise
        while (items_sent < 450) begin
            len = $urandom_range(1, 12);
            if (prog_len + len > PDEPTH) len = 0;
            for (int i = 0; i < len; i++) begin
                ins = ($urandom_range(0, 3) == 0) ? rand_flow(prog_len + len)
                      : (rand_operand_pair() | {8'($urandom_range(0, 15)), 24'd0});
                row(sbi_pkg::ACT_APPEND, ins, $urandom);
            end
            row(sbi_pkg::ACT_EXEC,
                {($urandom_range(0, 3) == 0) ? sbi_pkg::OP_RUN : sbi_pkg::OP_DBG,
                 sbi_pkg::TY_IMM, 8'(prog_len + len - $urandom_range(1, len + 1)), 12'd0}, 0);
            steps = $urandom_range(2, 20);
            for (int i = 0; i < steps; i++) row(sbi_pkg::ACT_STEP, 0, $urandom);
            for (int i = 0; i < $urandom_range(0, 4); i++) begin
                ins = $urandom;
                if ($urandom_range(0, 3) != 0) ins = {8'($urandom_range(0, 24)), ins[23:0]};
                row(2'($urandom_range(0, 3)) == sbi_pkg::ACT_APPEND ? sbi_pkg::ACT_EXEC
                                                                    : 2'($urandom_range(0, 3)),
                    ins, $urandom);
            end
            // bursts with gaps; keep offering while the receiver holds off
            foreach (table_rows[i]) begin
                send(table_rows[i]);
                items_sent++;
                if (!hold_off && $urandom_range(0, 4) == 0) begin
                    gap = $urandom_range(1, 8);
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            table_rows.delete();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_traces.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/sbi_pkg.sv
hdl/sbi_divider.sv
hdl/script_bytecode_interpreter.sv
tb/testbench.sv
